// ----- sv/per_core_ready_queue_manager_top_macros.svh -----
// Assertion macros shared by the ready queue manager.
`ifndef PER_CORE_READY_QUEUE_MANAGER_TOP_MACROS_SVH
`define PER_CORE_READY_QUEUE_MANAGER_TOP_MACROS_SVH
// Assert an implication on every rising clock edge outside reset.
`define RQM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Assert an implication whose consequent must hold in the next cycle.
`define RQM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- sv/rqm_pkg.sv -----
// ----------------------------------------------------------------------------
// rqm_pkg
// Shared types, codes and default sizes of the ready queue manager.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package rqm_pkg;
   localparam int CORES_DEFAULT = 4;
   localparam int QUEUE_DEPTH_DEFAULT = 16;

   localparam logic [2:0] CMD_INSERT = 3'd0;
   localparam logic [2:0] CMD_POP_HEAD = 3'd1;
   localparam logic [2:0] CMD_POP_UNPINNED = 3'd2;
   localparam logic [2:0] CMD_SET_RUNNING = 3'd3;
   localparam logic [2:0] CMD_READ_RUNNING = 3'd4;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_INVAL = 2'd3;

   typedef struct packed {
      logic [2:0] command;
      logic [2:0] core;
      logic [7:0] thread_id;
      logic [3:0] affinity;
      logic       at_head;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] out_thread;
      logic [3:0] out_affinity;
      logic [4:0] queue_count;
   } rsp_type;

   typedef struct packed {
      logic [7:0] thread_id;
      logic [3:0] affinity;
   } entry_type;

   // Per-step control broadcast from the sequencer to every cell.
   typedef struct packed {
      logic       run;
      logic       first;
      logic       ins_head;
      logic       ins_tail;
      logic       remove;
      logic       scan;
      entry_type  new_entry;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_DONE
   } state_type;
endpackage

// ----- sv/per_core_ready_queue_manager_top.sv -----
// ----------------------------------------------------------------------------
// per_core_ready_queue_manager_top
// Per-core bounded ready queues of threads with affinity tags.
// ----------------------------------------------------------------------------
// Usage: one command transaction enters on req_* (valid/stall) and yields
// exactly one result transaction on rsp_* (valid/stall). Each core queue is
// a row of cells; an insert or removal shifts the affected cells of the row
// together. The sequencer walks the addressed row one cell per cycle to
// find the first unpinned entry. After acceptance the command passes the
// WALK state (repeated once per scanned cell for pop-first-unpinned) and
// the DONE state, which registers the result; the sequencer then returns
// to IDLE. One command is in flight at a time; the next is accepted once
// the result has been registered and is not held by a stalled receiver.
// When rsp_stall is high the result register holds its transaction
// unchanged.
// Synchronous reset empties every queue count and clears the running
// threads; queue contents are not cleared since only counted entries are
// ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "per_core_ready_queue_manager_top_macros.svh"
module per_core_ready_queue_manager_top #(
   parameter int CORES = rqm_pkg::CORES_DEFAULT,
   parameter int QUEUE_DEPTH = rqm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rqm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rqm_pkg::rsp_type rsp_data
);
   import rqm_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH + 1);
   localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   cell_ctl_type ctl;
   entry_type cells [CORES][QUEUE_DEPTH];
   entry_type scan_entry;
   logic [IW-1:0] scan_index;
   logic [PW-1:0] cut_pos;
   logic [PW-1:0] count_sel;
   logic [2:0] core_q;

   // The core of the incoming request picks the row when it is accepted.
   assign core_q = req_data.core;

   rqm_ctrl #(.CORES(CORES), .QUEUE_DEPTH(QUEUE_DEPTH)) u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .scan_entry(scan_entry), .scan_index(scan_index), .cut_pos(cut_pos),
      .count_sel(count_sel), .ctl(ctl)
   );

   // The row under scan is tracked locally from the accepted transaction.
   logic [2:0] row_ff, row_in;
   assign row_in = (req_valid && !req_stall) ? core_q : row_ff;
   always_ff @(posedge clock) begin
      row_ff <= row_in;
   end

   always_comb begin
      scan_entry = '0;
      for (int c = 0; c < CORES; c++) begin
         if (32'(row_ff) == c) scan_entry = cells[c][scan_index];
      end
   end

   // An insert at the head shifts cells up to and including the count; a removal
   // shifts cells at or past the cut position and below the count; a tail insert writes the count cell.
   for (genvar c = 0; c < CORES; c++) begin : g_core
      for (genvar p = 0; p < QUEUE_DEPTH; p++) begin : g_cell
         logic act;
         assign act = ctl.ins_head ? (32'(p) <= 32'(count_sel)) :
                      (32'(p) >= 32'(cut_pos) && 32'(p) + 1 < 32'(count_sel) + 1);
         rqm_cell u_cell (
            .clock(clock), .ctl(ctl),
            .sel_core(32'(row_ff) == c),
            .active(act),
            .at_remove(32'(p) == 32'(count_sel)),
            .is_pos0(p == 0),
            .left_entry(cells[c][(p == 0) ? 0 : p - 1]),
            .right_entry(cells[c][(p == QUEUE_DEPTH - 1) ? p : p + 1]),
            .entry(cells[c][p])
         );
      end
   end

   `RQM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")
   `RQM_ASSERT_NEXT(a_accept_blocks, clock, reset, req_valid && !req_stall, req_stall, "accepted while busy")
   `RQM_ASSERT_IMP(a_count_range, clock, reset, rsp_valid, 32'(rsp_data.queue_count) <= QUEUE_DEPTH, "count beyond depth")
endmodule

// ----- sv/rqm_cell.sv -----
// ----------------------------------------------------------------------------
// rqm_cell
// One queue position of one core: holds an entry and shifts with neighbors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rqm_cell (
   input  logic                 clock,
   input  rqm_pkg::cell_ctl_type ctl,
   input  logic                 sel_core,
   input  logic                 active,
   input  logic                 at_remove,
   input  logic                 is_pos0,
   input  rqm_pkg::entry_type   left_entry,
   input  rqm_pkg::entry_type   right_entry,
   output rqm_pkg::entry_type   entry
);
   import rqm_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // A cell of the selected core updates only in the commit step (first) of a command.
   always_comb begin
      entry_in = entry_ff;
      if (ctl.run && ctl.first && sel_core) begin
         if (ctl.ins_head && active) begin
            entry_in = is_pos0 ? ctl.new_entry : left_entry;
         end else if (ctl.ins_tail && at_remove) begin
            entry_in = ctl.new_entry;
         end else if (ctl.remove && active) begin
            entry_in = right_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
endmodule

// ----- sv/rqm_ctrl.sv -----
// ----------------------------------------------------------------------------
// rqm_ctrl
// Command sequencer: for pop-first-unpinned scans a core's cells one per cycle, then commits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rqm_ctrl #(
   parameter int CORES = rqm_pkg::CORES_DEFAULT,
   parameter int QUEUE_DEPTH = rqm_pkg::QUEUE_DEPTH_DEFAULT,
   localparam int PW = $clog2(QUEUE_DEPTH + 1),
   localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rqm_pkg::req_type      req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rqm_pkg::rsp_type      rsp_data,
   input  rqm_pkg::entry_type    scan_entry,
   output logic [IW-1:0]         scan_index,
   output logic [PW-1:0]         cut_pos,
   output logic [PW-1:0]         count_sel,
   output rqm_pkg::cell_ctl_type ctl
);
   import rqm_pkg::*;

   localparam int CW = (CORES > 1) ? $clog2(CORES) : 1;

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [PW-1:0] count_ff [CORES];
   logic [PW-1:0] count_in [CORES];
   logic [7:0] run_ff [CORES];
   logic [7:0] run_in [CORES];
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic found_ff, found_in;
   logic core_ok;
   logic [CW-1:0] core_idx;
   logic accept;
   logic [PW-1:0] n;
   logic hit;

   assign accept = req_valid && !req_stall;
   assign core_ok = {29'd0, req_ff.core} < 32'(CORES);
   assign core_idx = req_ff.core[CW-1:0];
   assign n = core_ok ? count_ff[core_idx] : '0;
   assign count_sel = n;
   assign scan_index = pos_ff[IW-1:0];
   assign hit = ({28'd0, scan_entry.affinity} >= 32'(CORES));
   assign cut_pos = pos_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (accept) state_in = S_WALK;
         S_WALK: begin
            if (req_ff.command != CMD_POP_UNPINNED || !core_ok || pos_ff >= n ||
                hit) begin
               state_in = S_DONE;
            end
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_in = req_ff;
      pos_in = pos_ff;
      found_in = found_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      count_in = count_ff;
      run_in = run_ff;
      ctl = '0;
      ctl.new_entry.thread_id = req_ff.thread_id;
      ctl.new_entry.affinity = req_ff.affinity;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in = req_data;
               pos_in = '0;
               found_in = 1'b0;
            end
         end
         S_WALK: begin
            if (req_ff.command == CMD_POP_UNPINNED && core_ok && pos_ff < n) begin
               if (hit) found_in = 1'b1; else pos_in = pos_ff + 1'b1;
            end else if (req_ff.command == CMD_POP_HEAD) begin
               pos_in = '0;
            end
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_in = '0;
            if (!core_ok) begin
               rsp_in.status = ST_INVAL;
            end else begin
               ctl.run = 1'b1;
               ctl.first = 1'b1;
               case (req_ff.command)
                  CMD_INSERT: begin
                     if (req_ff.thread_id == 8'd0) rsp_in.status = ST_INVAL;
                     else if (32'(n) >= 32'(QUEUE_DEPTH)) rsp_in.status = ST_FULL;
                     else begin
                        ctl.ins_head = req_ff.at_head;
                        ctl.ins_tail = !req_ff.at_head;
                        pos_in = n;
                        count_in[core_idx] = n + 1'b1;
                     end
                  end
                  CMD_POP_HEAD, CMD_POP_UNPINNED: begin
                     if ((req_ff.command == CMD_POP_HEAD && n == '0) ||
                         (req_ff.command == CMD_POP_UNPINNED && !found_ff)) begin
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        ctl.remove = 1'b1;
                        rsp_in.out_thread = scan_entry.thread_id;
                        rsp_in.out_affinity = scan_entry.affinity;
                        count_in[core_idx] = n - 1'b1;
                     end
                  end
                  CMD_SET_RUNNING: begin
                     if (req_ff.thread_id == 8'd0) rsp_in.status = ST_INVAL;
                     else begin
                        run_in[core_idx] = req_ff.thread_id;
                        rsp_in.out_thread = req_ff.thread_id;
                     end
                  end
                  CMD_READ_RUNNING: rsp_in.out_thread = run_ff[core_idx];
                  default: rsp_in.status = ST_INVAL;
               endcase
               rsp_in.queue_count = 5'(count_in[core_idx]);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CORES; c++) begin
            count_ff[c] <= '0;
            run_ff[c] <= '0;
         end
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff <= count_in;
         run_ff <= run_in;
      end
      req_ff <= req_in;
      pos_ff <= pos_in;
      found_ff <= found_in;
      rsp_ff <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule

// ----- verif/per_core_ready_queue_manager_top_tb.sv -----
// ----------------------------------------------------------------------------
// per_core_ready_queue_manager_top_tb
// Drives command transactions into the ready queue manager with random gaps
// and random result stalls. A behavioral model of the per-core queues and
// running slots predicts every result, and a checker compares each result
// transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module per_core_ready_queue_manager_top_tb;
   import rqm_pkg::*;

   localparam int NCORES = CORES_DEFAULT;
   localparam int DEPTH = QUEUE_DEPTH_DEFAULT;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   per_core_ready_queue_manager_top u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   // Shadow copy of the block's state. Only entries below the count of a
   // core are meaningful, so the arrays need no clearing.
   entry_type  shadow_queue [NCORES][DEPTH];
   int         shadow_count [NCORES];
   logic [7:0] shadow_running [NCORES];
   rsp_type    pending_results [$];
   int         error_count;

   // The clock runs high for 2 ns and low for 2 ns.
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Removes position pos of a core's queue and closes the gap.
   function automatic entry_type remove_entry(int c, int pos);
      entry_type e;
      e = shadow_queue[c][pos];
      for (int i = pos; i + 1 < shadow_count[c]; i++)
         shadow_queue[c][i] = shadow_queue[c][i + 1];
      shadow_count[c]--;
      return e;
   endfunction

   // Applies one command to the shadow state and returns the result it
   // must produce.
   function automatic rsp_type predict_command(req_type cmd);
      rsp_type   r;
      entry_type e;
      int        c;
      r = '0;
      r.status = ST_OK;
      c = cmd.core;
      if (c >= NCORES) begin
         r.status = ST_INVAL;
         return r;
      end
      case (cmd.command)
         CMD_INSERT: begin
            if (cmd.thread_id == 8'd0) begin
               r.status = ST_INVAL;
            end else if (shadow_count[c] >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               e.thread_id = cmd.thread_id;
               e.affinity = cmd.affinity;
               if (cmd.at_head) begin
                  for (int i = shadow_count[c]; i > 0; i--)
                     shadow_queue[c][i] = shadow_queue[c][i - 1];
                  shadow_queue[c][0] = e;
               end else begin
                  shadow_queue[c][shadow_count[c]] = e;
               end
               shadow_count[c]++;
            end
         end
         CMD_POP_HEAD: begin
            if (shadow_count[c] == 0) begin
               r.status = ST_EMPTY;
            end else begin
               e = remove_entry(c, 0);
               r.out_thread = e.thread_id;
               r.out_affinity = e.affinity;
            end
         end
         CMD_POP_UNPINNED: begin
            r.status = ST_EMPTY;
            for (int i = 0; i < shadow_count[c]; i++) begin
               if (shadow_queue[c][i].affinity >= NCORES) begin
                  e = remove_entry(c, i);
                  r.out_thread = e.thread_id;
                  r.out_affinity = e.affinity;
                  r.status = ST_OK;
                  break;
               end
            end
         end
         CMD_SET_RUNNING: begin
            if (cmd.thread_id == 8'd0) begin
               r.status = ST_INVAL;
            end else begin
               shadow_running[c] = cmd.thread_id;
               r.out_thread = cmd.thread_id;
            end
         end
         CMD_READ_RUNNING: begin
            r.out_thread = shadow_running[c];
         end
         default: begin
            r.status = ST_INVAL;
         end
      endcase
      r.queue_count = 5'(shadow_count[c]);
      return r;
   endfunction

   // Sends one command transaction after a random gap. The payload is held
   // while the block stalls, and the prediction is queued on acceptance.
   // Valid drops only during a gap, so it is driven once per time step.
   task automatic send_command(req_type cmd);
      int gap;
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= cmd;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(predict_command(cmd));
      @(negedge clock);
   endtask

   function automatic req_type make_command(logic [2:0] op, int c, int tid, int aff,
                                            logic head);
      req_type q;
      q.command = op;
      q.core = 3'(c);
      q.thread_id = 8'(tid);
      q.affinity = 4'(aff);
      q.at_head = head;
      return q;
   endfunction

   // After each accepted result the receiver draws a new random stall, and
   // in quiet stretches it never stalls at all.
   int stall_left;
   logic quiet_stretch;
   initial begin
      rsp_stall = 1'b1;
      stall_left = 0;
      quiet_stretch = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 199) == 0)
            quiet_stretch = ~quiet_stretch;
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Every accepted result transaction is compared with the oldest
   // prediction; a result with nothing outstanding is itself an error.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
            error_count++;
         end else begin
            rsp_type want;
            want = pending_results.pop_front();
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_data.status);
               error_count++;
            end
            if (rsp_data.out_thread !== want.out_thread) begin
               $display("%0t: out_thread expected %0d actual %0d", $time,
                        want.out_thread, rsp_data.out_thread);
               error_count++;
            end
            if (rsp_data.out_affinity !== want.out_affinity) begin
               $display("%0t: out_affinity expected %0d actual %0d", $time,
                        want.out_affinity, rsp_data.out_affinity);
               error_count++;
            end
            if (rsp_data.queue_count !== want.queue_count) begin
               $display("%0t: queue_count expected %0d actual %0d", $time,
                        want.queue_count, rsp_data.queue_count);
               error_count++;
            end
         end
         if (!quiet_stretch)
            stall_left = $urandom_range(0, 8);
      end
   end

   // Directed checks: empty pops, invalid arguments, unknown commands,
   // running slot handling, and filling one queue past its depth.
   task automatic test_directed();
      send_command(make_command(CMD_POP_HEAD, 0, 0, 0, 1'b0));
      send_command(make_command(CMD_POP_UNPINNED, 1, 0, 0, 1'b0));
      send_command(make_command(CMD_READ_RUNNING, 2, 0, 0, 1'b0));
      send_command(make_command(CMD_INSERT, 0, 0, 5, 1'b0));
      send_command(make_command(CMD_SET_RUNNING, 3, 0, 0, 1'b0));
      send_command(make_command(CMD_SET_RUNNING, 3, 255, 15, 1'b1));
      send_command(make_command(CMD_READ_RUNNING, 3, 0, 0, 1'b0));
      send_command(make_command(CMD_INSERT, 7, 9, 0, 1'b0));
      send_command(make_command(CMD_POP_HEAD, 4, 0, 0, 1'b0));
      send_command(make_command(3'd5, 1, 1, 1, 1'b1));
      send_command(make_command(3'd7, 2, 0, 0, 1'b0));
      send_command(make_command(CMD_INSERT, 1, 1, 1, 1'b0));
      send_command(make_command(CMD_POP_UNPINNED, 1, 0, 0, 1'b0));
      // Fill core 0 past its depth with mixed affinities and ends.
      for (int i = 0; i <= DEPTH; i++)
         send_command(make_command(CMD_INSERT, 0, 200 + i, (i * 5) % 16, 1'(i % 2)));
      for (int i = 0; i < 6; i++)
         send_command(make_command(CMD_POP_UNPINNED, 0, 0, 0, 1'b0));
   endtask

   // Random commands, weighted toward valid cores and toward inserts and
   // pops so that queues fill, empty and run full repeatedly.
   task automatic test_random(int count);
      req_type q;
      for (int n = 0; n < count; n++) begin
         q.command = 3'($urandom_range(0, 99) < 92 ? $urandom_range(0, 4)
                                                  : $urandom_range(5, 7));
         if (q.command <= CMD_POP_UNPINNED && $urandom_range(0, 2) == 0)
            q.command = CMD_INSERT;
         q.core = 3'($urandom_range(0, 99) < 90 ? $urandom_range(0, NCORES - 1)
                                                : $urandom_range(0, 7));
         q.thread_id = 8'($urandom_range(0, 19) == 0 ? 0 : $urandom_range(1, 255));
         q.affinity = 4'($urandom_range(0, 15));
         q.at_head = 1'($urandom_range(0, 1));
         send_command(q);
      end
   endtask

   initial begin
      error_count = 0;
      for (int c = 0; c < NCORES; c++) begin
         shadow_count[c] = 0;
         shadow_running[c] = 8'd0;
      end
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(620);
      req_valid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (40) @(posedge clock);
      if (error_count == 0)
         $display("per_core_ready_queue_manager_top_tb passed");
      else
         $display("per_core_ready_queue_manager_top_tb failed");
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #2000000;
      $display("per_core_ready_queue_manager_top_tb failed");
      $finish;
   end
endmodule
